FILE: src/stcp_pkg.sv
`timescale 1ns / 1ps

package stcp_pkg;

    localparam logic [7:0] CHAR_V    = 8'h56;
    localparam logic [7:0] CHAR_D    = 8'h44;
    localparam logic [7:0] CHAR_P    = 8'h50;
    localparam logic [7:0] CHAR_I    = 8'h49;
    localparam logic [7:0] CHAR_T    = 8'h54;
    localparam logic [7:0] CHAR_S    = 8'h53;
    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_NINE = 8'h39;

    localparam logic [6:0] CODE_SAVE      = 7'd15;
    localparam logic [6:0] CODE_RUN_ON    = 7'd20;
    localparam logic [6:0] CODE_RUN_OFF   = 7'd25;
    localparam logic [6:0] CODE_COLOR_OFF = 7'd50;
    localparam logic [6:0] CODE_COLOR_ON  = 7'd55;

    localparam logic [1:0] LAST_SLOT = 2'd2;
    localparam logic [1:0] FULL_SLOT = 2'd3;

    typedef struct packed {
        logic       save_request;
        logic       line_color;
        logic       run_enable;
        logic [6:0] pwm_period;
        logic [6:0] deriv_gain;
        logic [6:0] prop_gain;
        logic [6:0] speed_setpoint;
        logic       command_ok;
    } result_t;

    function automatic logic is_letter(input logic [7:0] c);
        return (c == CHAR_V) || (c == CHAR_D) || (c == CHAR_P) ||
               (c == CHAR_I) || (c == CHAR_T) || (c == CHAR_S);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
    endfunction

endpackage

FILE: src/serial_tuning_command_parser.sv
`timescale 1ns / 1ps
// Input transaction to result: the input register, then the result register.
// One byte per cycle unless stalled; the third byte of a frame yields one result transaction.
// The input side stalls only while a result waits and the registered byte would emit another.
// Reset: asynchronous, active low; clears byte count, held values, flags and valid bits.

module serial_tuning_command_parser
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // rx_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // command_ok, speed_setpoint[7:1], prop_gain[14:8], deriv_gain[21:15],
    // pwm_period[28:22], run_enable, line_color, save_request
    output logic [31:0] m_axis_tdata
);
    import stcp_pkg::*;

    logic             in_valid_reg, in_valid_next;
    logic [7:0]       in_byte_reg;
    logic [1:0]       count_reg, count_next;
    logic [7:0]       op_reg, op_next;
    logic [7:0]       d1_reg, d1_next;
    logic [6:0]       speed_reg, speed_next;
    logic [6:0]       kp_reg, kp_next;
    logic [6:0]       kd_reg, kd_next;
    logic [6:0]       period_reg, period_next;
    logic             run_reg, run_next;
    logic             color_reg, color_next;
    logic             out_valid_reg, out_valid_next;
    result_t          out_data_reg, out_data_next;

    logic [1:0]       slot;
    logic             drop;
    logic             emit;
    logic             advance;
    logic             ok;
    logic             save;
    logic [6:0]       num;

    always_comb
    begin
        slot    = is_letter(in_byte_reg) ? 2'd0 : count_reg;
        drop    = (slot == FULL_SLOT);
        emit    = (slot == LAST_SLOT);
        advance = in_valid_reg && (!emit || !out_valid_reg || m_axis_tready);

        ok  = is_letter(op_reg) && is_digit(d1_reg) && is_digit(in_byte_reg);
        num = ({3'd0, d1_reg[3:0]} << 3) + ({3'd0, d1_reg[3:0]} << 1)
              + {3'd0, in_byte_reg[3:0]};

        count_next  = count_reg;
        op_next     = op_reg;
        d1_next     = d1_reg;
        speed_next  = speed_reg;
        kp_next     = kp_reg;
        kd_next     = kd_reg;
        period_next = period_reg;
        run_next    = run_reg;
        color_next  = color_reg;
        save        = 1'b0;

        if (advance)
        begin
            count_next = drop ? 2'd0 : slot + 2'd1;
            if (slot == 2'd0)
            begin
                op_next = in_byte_reg;
            end
            if (slot == 2'd1)
            begin
                d1_next = in_byte_reg;
            end
            if (emit && ok)
            begin
                case (op_reg)
                    CHAR_V:  speed_next  = num;
                    CHAR_P:  kp_next     = num;
                    CHAR_D:  kd_next     = num;
                    CHAR_T:  period_next = num;
                    CHAR_S:
                    begin
                        if (num == CODE_SAVE)      save       = 1'b1;
                        if (num == CODE_RUN_ON)    run_next   = 1'b1;
                        if (num == CODE_RUN_OFF)   run_next   = 1'b0;
                        if (num == CODE_COLOR_OFF) color_next = 1'b0;
                        if (num == CODE_COLOR_ON)  color_next = 1'b1;
                    end
                    default: ;
                endcase
            end
        end

        out_data_next.command_ok     = ok;
        out_data_next.speed_setpoint = speed_next;
        out_data_next.prop_gain      = kp_next;
        out_data_next.deriv_gain     = kd_next;
        out_data_next.pwm_period     = period_next;
        out_data_next.run_enable     = run_next;
        out_data_next.line_color     = color_next;
        out_data_next.save_request   = save;

        if (advance && emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end

        if (s_axis_tvalid && s_axis_tready)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
        else
        begin
            in_valid_next = in_valid_reg;
        end
    end

    assign s_axis_tready = !in_valid_reg || advance;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            count_reg     <= 2'd0;
            speed_reg     <= 7'd0;
            kp_reg        <= 7'd0;
            kd_reg        <= 7'd0;
            period_reg    <= 7'd0;
            run_reg       <= 1'b0;
            color_reg     <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            count_reg     <= count_next;
            speed_reg     <= speed_next;
            kp_reg        <= kp_next;
            kd_reg        <= kd_next;
            period_reg    <= period_next;
            run_reg       <= run_next;
            color_reg     <= color_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_byte_reg <= s_axis_tdata;
        end
        op_reg <= op_next;
        d1_reg <= d1_next;
        if (advance && emit)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_data_reg.save_request |-> out_data_reg.command_ok)
        else $error("save request without valid command");

    assert property (@(posedge clk) disable iff (!rst_n)
        (speed_reg <= 7'd99) && (kp_reg <= 7'd99) && (kd_reg <= 7'd99) &&
        (period_reg <= 7'd99))
        else $error("held value out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        !(advance && emit) |=> $stable(run_reg) && $stable(color_reg) &&
                               $stable(speed_reg))
        else $error("setting changed without a complete frame");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && m_axis_tready && !(advance && emit) |=> !out_valid_reg)
        else $error("result repeated after transaction");

endmodule
